### hdl/psched_pkg.sv
// Shared constants, types and helper functions of the periodic stream scheduler.
`timescale 1ns / 1ps

package psched_pkg;

	localparam int REG_COUNT        = 8;
	localparam int IDX_W            = 3;
	localparam int TIME_W           = 32;
	localparam int PERIOD_W         = 16;
	localparam int CFG_INDEX_W      = 4;
	localparam int STREAM_COUNT_DEF = 8;

	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd1000;

	// Write into the timer bank, already filtered to valid register indexes.
	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    idx;
		logic [PERIOD_W-1:0] data;
	} cfg_wr_t;

	// Scan step driven by the sequencer into the shared compare unit.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] now;
	} scan_ctl_t;

	function automatic logic [PERIOD_W-1:0] reset_interval(input logic [IDX_W-1:0] idx);
		logic [PERIOD_W-1:0] val;
		val = '0;
		if (idx == IDX_W'(0) || idx == IDX_W'(1)) begin
			val = DEFAULT_PERIOD;
		end
		return val;
	endfunction

	// Priority encoder: index of the lowest set bit.
	function automatic logic [IDX_W-1:0] lowest_index(input logic [REG_COUNT-1:0] mask);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = REG_COUNT - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### hdl/psched_if.sv
// Handshake channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps

interface req_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ticks;

	modport source (output valid, output now_ticks, input ready);
	modport sink (input valid, input now_ticks, output ready);
endinterface

interface res_if;
	logic       valid;
	logic       ready;
	logic [2:0] stream_index;
	logic       last_of_run;

	modport source (output valid, output stream_index, output last_of_run, input ready);
	modport sink (input valid, input stream_index, input last_of_run, output ready);
endinterface

interface cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/psched_bank.sv
// Interval and last-send registers with the shared elapsed-time compare unit.
`timescale 1ns / 1ps

module psched_bank
	import psched_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg_wr,
	input  logic [TIME_W-1:0] latest_time,
	input  scan_ctl_t         scan,
	output logic              due
);

	logic [PERIOD_W-1:0] interval_q  [REG_COUNT];
	logic [TIME_W-1:0]   last_sent_q [REG_COUNT];
	logic [TIME_W-1:0]   elapsed;
	logic [PERIOD_W-1:0] period;

	// One subtract and one compare, shared by all streams over the scan.
	always_comb begin
		period  = interval_q[scan.idx];
		elapsed = scan.now - last_sent_q[scan.idx];
		due     = (period != '0) && (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				interval_q[i]  <= reset_interval(IDX_W'(i));
				last_sent_q[i] <= '0;
			end
		end else begin
			// Restart the timer of a stream whose period is rewritten.
			if (cfg_wr.en) begin
				interval_q[cfg_wr.idx]  <= cfg_wr.data;
				last_sent_q[cfg_wr.idx] <= latest_time;
			end
			if (scan.en && due) begin
				last_sent_q[scan.idx] <= scan.now;
			end
		end
	end

endmodule

### hdl/psched_seq.sv
// Scan sequencer: walks the streams, collects due ones, then issues them in order.
`timescale 1ns / 1ps

module psched_seq
	import psched_pkg::*;
#(
	parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	req_if.sink               req,
	res_if.source             res,
	input  logic              due,
	output scan_ctl_t         scan,
	output logic [TIME_W-1:0] latest_time
);

	localparam int SCAN_LIMIT = (STREAM_COUNT < REG_COUNT) ? STREAM_COUNT : REG_COUNT;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LIMIT - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [REG_COUNT-1:0] mask_q;
	logic [TIME_W-1:0]    now_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 out_free;
	logic                 issue;
	logic [IDX_W-1:0]     pick;
	logic [REG_COUNT-1:0] rest;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign issue     = (state_q == ST_EMIT) && (mask_q != '0) && out_free;
	assign pick      = lowest_index(mask_q);
	assign rest      = mask_q & ~(REG_COUNT'(1) << pick);

	assign scan.en     = (state_q == ST_SCAN);
	assign scan.idx    = idx_q;
	assign scan.now    = now_q;
	assign latest_time = now_q;

	assign res.valid        = out_valid_q;
	assign res.stream_index = out_idx_q;
	assign res.last_of_run  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			mask_q      <= '0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// Load the output register on issue, otherwise drop it once taken.
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q   <= req.now_ticks;
						idx_q   <= '0;
						mask_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (due) begin
						mask_q[idx_q] <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (mask_q == '0) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_idx_q   <= pick;
						out_last_q  <= (rest == '0);
						mask_q      <= rest;
						if (rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/periodic_stream_scheduler_top.sv
// Top level of the periodic stream scheduler: timer bank, scan sequencer, register port.
`timescale 1ns / 1ps

//  channel | dir | payload                          | role
//  req     | in  | now_ticks[31:0]                  | service request with current tick time
//  res     | out | stream_index[2:0], last_of_run   | one due stream, last one of a run marked
//  cfg     | in  | index[3:0], data[15:0]           | stream period write, always ready
//
//  After a request is accepted, the scan walks min(STREAM_COUNT, 8) streams in index order,
//  one stream per cycle, through the single elapsed-time compare.
//  Due streams then leave one per cycle through the output register, which may still hold
//  the final result while the next request is taken. Output stalls hold the issue phase.
//  Reset (arst_n low) restores the default periods and clears all last-send times.

module periodic_stream_scheduler_top
	import psched_pkg::*;
#(
	parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	req_if.sink   req,
	res_if.source res,
	cfg_if.sink   cfg
);

	cfg_wr_t           cfg_wr;
	scan_ctl_t         scan;
	logic              due;
	logic [TIME_W-1:0] latest_time;

	// Register writes land in the bank registers; drop indexes past the last stream register.
	assign cfg.ready   = 1'b1;
	assign cfg_wr.en   = cfg.valid && (cfg.index < CFG_INDEX_W'(REG_COUNT));
	assign cfg_wr.idx  = cfg.index[IDX_W-1:0];
	assign cfg_wr.data = cfg.data;

	// Period and last-send storage plus the shared compare unit.
	psched_bank u_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.latest_time (latest_time),
		.scan        (scan),
		.due         (due)
	);

	// Walk streams in index order, then issue the due ones.
	psched_seq #(
		.STREAM_COUNT (STREAM_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.res         (res),
		.due         (due),
		.scan        (scan),
		.latest_time (latest_time)
	);

	// An accepted request keeps the block busy for at least the scan.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while scan in progress");

	// A run that is not finished keeps the block from taking a new request.
	a_run_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.last_of_run) |-> !req.ready)
		else $error("new request taken before run completed");

	// After a non-final result is taken, the next one follows immediately.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last_of_run) |=> res.valid)
		else $error("run broke off before its final result");

endmodule

### verif/tb_periodic_stream_scheduler_top.sv
// Self-checking testbench of the periodic stream scheduler: directed table, then random phases.
`timescale 1ns / 1ps

module tb_periodic_stream_scheduler_top;
	import psched_pkg::*;

	// Scanned streams: the parameter, capped by the register bank and the index field.
	localparam int SCANNED       = (STREAM_COUNT_DEF < REG_COUNT) ? STREAM_COUNT_DEF : REG_COUNT;
	// Settle wait: long enough for the scan and issue phase of a request plus the output register.
	localparam int SETTLE_CYCLES = 32;
	// Cycles with no handshake anywhere before the run is declared hung.
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASE_COUNT   = 11;
	localparam int PHASE_REQS    = 20;
	localparam int DIRECTED_ROWS = 30;

	typedef enum logic [0:0] {
		ROW_WRITE,
		ROW_SERVICE
	} row_kind_t;

	// One line of the directed table: a period write or a service request.
	// When typed is set, due_mask is the set of streams the request must report.
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_INDEX_W-1:0] index;
		logic [TIME_W-1:0]     value;
		logic                  typed;
		logic [REG_COUNT-1:0]  due_mask;
	} stim_row_t;

	typedef struct packed {
		logic [IDX_W-1:0] stream_index;
		logic             last_of_run;
	} due_result_t;

	logic clk;
	logic arst_n;

	req_if req_ch ();
	res_if res_ch ();
	cfg_if cfg_ch ();

	periodic_stream_scheduler_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the timer bank.
	logic [PERIOD_W-1:0] period_q    [REG_COUNT];
	logic [TIME_W-1:0]   last_send_q [REG_COUNT];
	logic [TIME_W-1:0]   latest_seen;

	// Streams still owed by the block, oldest first.
	due_result_t pending_due [$];

	int fail_count = 0;
	bit quiet_tail = 1'b0;

	// Directed table. The early rows follow the reset periods (1000 on streams 0 and 1);
	// the later ones hit the period extremes, a step back in time and the 2^32 wrap.
	stim_row_t directed [DIRECTED_ROWS] = '{
		// write before any request: stream 5 restarts at time zero
		'{ROW_WRITE,   4'd5,  32'h0000_8000, 1'b0, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd0,         1'b1, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd999,       1'b1, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd1000,      1'b1, 8'h03},
		'{ROW_SERVICE, 4'd0,  32'd1999,      1'b1, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd2000,      1'b1, 8'h03},
		'{ROW_WRITE,   4'd2,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd3,  32'h0000_FFFF, 1'b0, 8'h00},
		// indexes past the bank: dropped
		'{ROW_WRITE,   4'd15, 32'h0000_AAAA, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd8,  32'h0000_5555, 1'b0, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd2000,      1'b1, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd2001,      1'b1, 8'h04},
		'{ROW_SERVICE, 4'd0,  32'd67534,     1'b1, 8'h27},
		// stream 3 reaches its full 65535-tick period exactly here
		'{ROW_SERVICE, 4'd0,  32'd67535,     1'b0, 8'h00},
		'{ROW_WRITE,   4'd0,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd1,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd2,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd3,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd4,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd5,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd6,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd7,  32'h0000_0001, 1'b0, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd67536,     1'b1, 8'hFF},
		// time runs backwards: looks like a very long elapsed time
		'{ROW_SERVICE, 4'd0,  32'd0,         1'b1, 8'hFF},
		'{ROW_SERVICE, 4'd0,  32'hFFFF_FFFF, 1'b1, 8'hFF},
		// wrap to zero: elapsed is one tick
		'{ROW_SERVICE, 4'd0,  32'd0,         1'b1, 8'hFF},
		'{ROW_WRITE,   4'd0,  32'h0000_0000, 1'b0, 8'h00},
		'{ROW_WRITE,   4'd7,  32'h0000_0000, 1'b0, 8'h00},
		'{ROW_SERVICE, 4'd0,  32'd5,         1'b1, 8'h7E},
		'{ROW_SERVICE, 4'd0,  32'd5,         1'b1, 8'h00}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Restore the reset periods and clear every last-send time.
	task automatic restore_timer_bank();
		for (int s = 0; s < REG_COUNT; s++) begin
			period_q[s]    = '0;
			last_send_q[s] = '0;
		end
		period_q[0] = DEFAULT_PERIOD;
		period_q[1] = DEFAULT_PERIOD;
		latest_seen = '0;
	endtask

	// A period write restarts that stream at the latest time seen; drop writes past the bank.
	task automatic retime_stream(input logic [CFG_INDEX_W-1:0] idx,
			input logic [PERIOD_W-1:0] period);
		if (idx < REG_COUNT) begin
			period_q[idx[IDX_W-1:0]]    = period;
			last_send_q[idx[IDX_W-1:0]] = latest_seen;
		end
	endtask

	// Scan the streams in index order, mark the due ones and advance their last send.
	function automatic logic [REG_COUNT-1:0] settle_due_streams(input logic [TIME_W-1:0] now);
		logic [REG_COUNT-1:0] due;
		logic [TIME_W-1:0]    elapsed;
		due         = '0;
		latest_seen = now;
		for (int s = 0; s < SCANNED; s++) begin
			if (period_q[s] != '0) begin
				elapsed = now - last_send_q[s];
				if (elapsed >= TIME_W'(period_q[s])) begin
					last_send_q[s] = now;
					due[s]         = 1'b1;
				end
			end
		end
		return due;
	endfunction

	// Queue one result per due stream, the highest index carrying the run marker.
	task automatic owe_due_streams(input logic [REG_COUNT-1:0] due);
		int top;
		top = -1;
		for (int s = 0; s < REG_COUNT; s++) begin
			if (due[s]) begin
				top = s;
			end
		end
		for (int s = 0; s < REG_COUNT; s++) begin
			if (due[s]) begin
				pending_due.push_back('{stream_index: IDX_W'(s), last_of_run: (s == top)});
			end
		end
	endtask

	// Drivers start and end at a falling edge. Valid stays high across back-to-back
	// requests; callers lower it before a gap or a settle.
	task automatic send_request(input logic [TIME_W-1:0] now,
			input bit typed, input logic [REG_COUNT-1:0] typed_mask);
		logic [REG_COUNT-1:0] due;
		req_ch.valid     <= 1'b1;
		req_ch.now_ticks <= now;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		due = settle_due_streams(now);
		owe_due_streams(typed ? typed_mask : due);
		@(negedge clk);
	endtask

	task automatic write_period(input logic [CFG_INDEX_W-1:0] idx,
			input logic [PERIOD_W-1:0] period);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= period;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		retime_stream(idx, period);
		@(negedge clk);
	endtask

	// Hold requests until every owed stream is out, then let a request with no due
	// stream finish its scan too.
	task automatic settle_block();
		req_ch.valid <= 1'b0;
		while (pending_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic sender_gap();
		int gap_len;
		gap_len = $urandom_range(1, 7);
		req_ch.valid <= 1'b0;
		repeat (gap_len) @(negedge clk);
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		logic [PERIOD_W-1:0] period;
		case ($urandom_range(0, 9))
			0: period = '0;
			1: period = '1;
			2: period = PERIOD_W'($urandom_range(0, 65535));
			default: period = PERIOD_W'($urandom_range(1, 30));
		endcase
		return period;
	endfunction

	// Mostly short steps so small periods fire often; now and then a jump anywhere,
	// a step back, or a gap long enough for the widest periods.
	function automatic logic [TIME_W-1:0] advance_time(input logic [TIME_W-1:0] prev);
		logic [TIME_W-1:0] next;
		case ($urandom_range(0, 19))
			0: next = $urandom;
			1: next = prev - TIME_W'($urandom_range(1, 500));
			2: next = prev + TIME_W'($urandom_range(30000, 70000));
			default: next = prev + TIME_W'($urandom_range(0, 40));
		endcase
		return next;
	endfunction

	initial begin : stimulus
		logic [TIME_W-1:0]      now;
		logic [CFG_INDEX_W-1:0] idx;
		bit                     owe_settle;
		bit                     gappy;
		int                     writes;

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.now_ticks = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		restore_timer_bank();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table: settle before any write that follows a request.
		owe_settle = 1'b0;
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed[r].kind == ROW_WRITE) begin
				if (owe_settle) begin
					settle_block();
					owe_settle = 1'b0;
				end
				write_period(directed[r].index, PERIOD_W'(directed[r].value));
			end else begin
				cfg_ch.valid <= 1'b0;
				send_request(directed[r].value, directed[r].typed, directed[r].due_mask);
				owe_settle = 1'b1;
			end
		end
		now = 32'd5;

		// Random phases: settle, reprogram, then a burst of requests.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle_block();
			if (p == 0 || p == 1) begin
				// extremes: every stream at the shortest, then at the longest period
				for (int s = 0; s < REG_COUNT; s++) begin
					write_period(CFG_INDEX_W'(s), (p == 0) ? PERIOD_W'(1) : '1);
				end
			end else begin
				writes = $urandom_range(2, 8);
				for (int w = 0; w < writes; w++) begin
					if ($urandom_range(0, 7) == 0) begin
						idx = CFG_INDEX_W'($urandom_range(8, 15));
					end else begin
						idx = CFG_INDEX_W'($urandom_range(0, 7));
					end
					write_period(idx, pick_period());
				end
			end
			cfg_ch.valid <= 1'b0;

			// start one phase just short of the wrap
			if (p == 3) begin
				now = 32'hFFFF_FFC0;
			end
			quiet_tail = (p == PHASE_COUNT - 1);
			gappy      = !quiet_tail && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_REQS; n++) begin
				if (gappy && $urandom_range(0, 3) == 0) begin
					sender_gap();
				end else if (!quiet_tail && $urandom_range(0, 39) == 0) begin
					settle_block();
				end
				now = advance_time(now);
				send_request(now, 1'b0, '0);
			end
		end

		settle_block();
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Result side back-pressure: random stall bursts, calm stretches, none in the tail.
	initial begin : result_ready_driver
		int  stall_len;
		int  stretch;
		bit  calm;
		res_ch.ready = 1'b0;
		stretch      = 0;
		calm         = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				calm    = ($urandom_range(0, 3) == 0);
				stretch = $urandom_range(20, 80);
			end else begin
				stretch--;
			end
			if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
				stall_len = $urandom_range(1, 7);
				res_ch.ready <= 1'b0;
				repeat (stall_len) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	// Compare every accepted result with the oldest owed stream.
	always @(posedge clk) begin : result_check
		due_result_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual stream %0d last %0b",
					$realtime, res_ch.stream_index, res_ch.last_of_run);
				fail_count++;
			end else begin
				want = pending_due.pop_front();
				if (res_ch.stream_index !== want.stream_index) begin
					$display("%0t: stream_index mismatch: expected %0d, actual %0d",
						$realtime, want.stream_index, res_ch.stream_index);
					fail_count++;
				end
				if (res_ch.last_of_run !== want.last_of_run) begin
					$display("%0t: last_of_run mismatch on stream %0d: expected %0b, actual %0b",
						$realtime, want.stream_index, want.last_of_run, res_ch.last_of_run);
					fail_count++;
				end
			end
		end
	end

	// End a hung run: count cycles with no handshake on any channel.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
					|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
					|| (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("%0t: no handshake for %0d cycles, %0d results still owed",
			$realtime, STALL_LIMIT, pending_due.size());
		$display("status: fail");
		$finish;
	end

endmodule
